@@ hdl/json_token_scanner_core_macros.svh @@
// Assertion macros used by the checker file of the scanner.
`ifndef JSON_TOKEN_SCANNER_CORE_MACROS_SVH
`define JSON_TOKEN_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define JTS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json_token_scanner_core: check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define JTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("json_token_scanner_core: check failed");

`endif

@@ hdl/jts_pkg.sv @@
`timescale 1ns / 1ps

package jts_pkg;

    // Result status codes.
    localparam logic [1:0] ST_TOKEN = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Token kinds.
    localparam logic [3:0] KIND_LBRACE   = 4'd0;
    localparam logic [3:0] KIND_RBRACE   = 4'd1;
    localparam logic [3:0] KIND_LBRACKET = 4'd2;
    localparam logic [3:0] KIND_RBRACKET = 4'd3;
    localparam logic [3:0] KIND_COMMA    = 4'd4;
    localparam logic [3:0] KIND_COLON    = 4'd5;
    localparam logic [3:0] KIND_NULL     = 4'd6;
    localparam logic [3:0] KIND_BOOLEAN  = 4'd7;
    localparam logic [3:0] KIND_NUMBER   = 4'd8;
    localparam logic [3:0] KIND_STRING   = 4'd9;

    // Keyword selectors.
    localparam logic [1:0] KW_NULL  = 2'd0;
    localparam logic [1:0] KW_TRUE  = 2'd1;
    localparam logic [1:0] KW_FALSE = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CH_LBRACE   = "{";
    localparam logic [7:0] CH_RBRACE   = "}";
    localparam logic [7:0] CH_LBRACKET = "[";
    localparam logic [7:0] CH_RBRACKET = "]";
    localparam logic [7:0] CH_COMMA    = ",";
    localparam logic [7:0] CH_COLON    = ":";
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SLASH    = "/";
    localparam logic [7:0] CH_SPACE    = " ";
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LOWER_B  = "b";
    localparam logic [7:0] CH_LOWER_F  = "f";
    localparam logic [7:0] CH_LOWER_N  = "n";
    localparam logic [7:0] CH_LOWER_R  = "r";
    localparam logic [7:0] CH_LOWER_T  = "t";
    localparam logic [7:0] CH_LOWER_U  = "u";

    // One result as it leaves the block.
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  kind;
        logic [15:0] pos;
    } result_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] w);
        return (w == KW_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [3:0] kw_kind(input logic [1:0] w);
        return (w == KW_NULL) ? KIND_NULL : KIND_BOOLEAN;
    endfunction

    // Byte p of keyword w; positions past the end read as zero.
    function automatic logic [7:0] kw_char(input logic [1:0] w, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case ({w, p})
            {KW_NULL, 3'd0}:  c = "n";
            {KW_NULL, 3'd1}:  c = "u";
            {KW_NULL, 3'd2}:  c = "l";
            {KW_NULL, 3'd3}:  c = "l";
            {KW_TRUE, 3'd0}:  c = "t";
            {KW_TRUE, 3'd1}:  c = "r";
            {KW_TRUE, 3'd2}:  c = "u";
            {KW_TRUE, 3'd3}:  c = "e";
            {KW_FALSE, 3'd0}: c = "f";
            {KW_FALSE, 3'd1}: c = "a";
            {KW_FALSE, 3'd2}: c = "l";
            {KW_FALSE, 3'd3}: c = "s";
            {KW_FALSE, 3'd4}: c = "e";
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/json_token_scanner_core.sv @@
`timescale 1ns / 1ps

// Channel   Direction  tdata                           tuser       tlast
// s_axis    in         [7:0] text_byte                 -           final_byte
// m_axis    out        [3:0] token_kind,               [1:0]       run_last
//                      [19:4] error_position           status
//
// A text byte is scanned in the cycle it is accepted; its results (zero to three)
// are loaded into a result group register and leave one per cycle while m_tready is high.
// A byte causing at most one result sustains one transfer per clock while m_tready is high;
// a byte causing more results holds the input until its last result leaves the single result port.
// The input is ready while the result group is empty or its last result is leaving.
// Reset (rst_n low) returns the scanner to idle at byte index zero with no results.

module json_token_scanner_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] token_kind, [19:4] error_position, rest zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // run_last
);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_KEYWORD = 3'd1;
    localparam logic [2:0] MODE_NUMBER  = 3'd2;
    localparam logic [2:0] MODE_STRING  = 3'd3;
    localparam logic [2:0] MODE_ESCAPE  = 3'd4;
    localparam logic [2:0] MODE_HEX     = 3'd5;

    logic [2:0]               mode_reg, mode_next;
    logic [1:0]               kw_which_reg, kw_which_next;
    logic [2:0]               kw_prog_reg, kw_prog_next;
    logic [2:0]               hex_left_reg, hex_left_next;
    logic [POSITION_BITS-1:0] byte_index_reg, byte_index_next;
    logic                     err_latched_reg, err_latched_next;

    jts_pkg::result_t grp_reg [3];
    jts_pkg::result_t grp_next [3];
    logic [1:0]       cnt_reg, cnt_next;
    logic [1:0]       rd_reg;

    logic       in_fire;
    logic       out_fire;
    logic       grp_last;
    logic [7:0] b;
    logic       fin;
    logic       num_v;
    logic       tok_v;
    logic [3:0] tok_kind;
    logic       err;
    logic       tail_v;
    logic       idle_scan;
    logic [2:0] hex_dec;
    logic [1:0] kw_sel;
    jts_pkg::result_t num_res, tok_res, tail_res;

    assign b        = s_tdata;
    assign fin      = s_tlast;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign grp_last = (rd_reg == cnt_reg - 2'd1);
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = !m_tvalid || (m_tready && grp_last);
    assign in_fire  = s_tvalid && s_tready;

    assign m_tdata  = {4'd0, grp_reg[rd_reg].pos, grp_reg[rd_reg].kind};
    assign m_tuser  = grp_reg[rd_reg].status;
    assign m_tlast  = grp_last;

    assign kw_sel  = (kw_which_reg == 2'd3) ? jts_pkg::KW_NULL : kw_which_reg;
    assign hex_dec = hex_left_reg - 3'd1;

    always_comb
    begin
        mode_next        = mode_reg;
        kw_which_next    = kw_which_reg;
        kw_prog_next     = kw_prog_reg;
        hex_left_next    = hex_left_reg;
        byte_index_next  = byte_index_reg + POSITION_BITS'(1);
        err_latched_next = err_latched_reg;
        num_v            = 1'b0;
        tok_v            = 1'b0;
        tok_kind         = jts_pkg::KIND_LBRACE;
        err              = 1'b0;
        idle_scan        = 1'b0;

        if (!err_latched_reg)
        begin
            case (mode_reg)
                MODE_NUMBER:
                begin
                    if (jts_pkg::is_digit(b))
                    begin
                        err = fin;
                    end
                    else
                    begin
                        num_v     = 1'b1;
                        idle_scan = 1'b1;
                    end
                end
                MODE_KEYWORD:
                begin
                    if (kw_prog_reg >= jts_pkg::kw_len(kw_sel) ||
                        b != jts_pkg::kw_char(kw_sel, kw_prog_reg))
                    begin
                        err = 1'b1;
                    end
                    else if (kw_prog_reg + 3'd1 == jts_pkg::kw_len(kw_sel))
                    begin
                        if (fin)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            tok_v     = 1'b1;
                            tok_kind  = jts_pkg::kw_kind(kw_sel);
                            mode_next = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        kw_prog_next = kw_prog_reg + 3'd1;
                        err          = fin;
                    end
                end
                MODE_STRING:
                begin
                    if (b == jts_pkg::CH_QUOTE)
                    begin
                        if (fin)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            tok_v     = 1'b1;
                            tok_kind  = jts_pkg::KIND_STRING;
                            mode_next = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        if (b == jts_pkg::CH_BSLASH)
                        begin
                            mode_next = MODE_ESCAPE;
                        end
                        err = fin;
                    end
                end
                MODE_ESCAPE:
                begin
                    if (b == jts_pkg::CH_SLASH || b == jts_pkg::CH_QUOTE ||
                        b == jts_pkg::CH_BSLASH || b == jts_pkg::CH_LOWER_B ||
                        b == jts_pkg::CH_LOWER_F || b == jts_pkg::CH_LOWER_N ||
                        b == jts_pkg::CH_LOWER_R || b == jts_pkg::CH_LOWER_T)
                    begin
                        mode_next = MODE_STRING;
                        err       = fin;
                    end
                    else if (b == jts_pkg::CH_LOWER_U)
                    begin
                        mode_next     = MODE_HEX;
                        hex_left_next = 3'd4;
                        err           = fin;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                MODE_HEX:
                begin
                    if (!jts_pkg::is_hex(b))
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        hex_left_next = hex_dec;
                        if (hex_dec == 3'd0)
                        begin
                            mode_next = MODE_STRING;
                        end
                        err = fin;
                    end
                end
                default:
                begin
                    idle_scan = 1'b1;
                end
            endcase

            // A byte between tokens, including the one that ended a number.
            if (idle_scan)
            begin
                mode_next = MODE_IDLE;
                if (!jts_pkg::is_space(b))
                begin
                    case (b)
                        jts_pkg::CH_LBRACE:
                        begin
                            tok_v    = 1'b1;
                            tok_kind = jts_pkg::KIND_LBRACE;
                        end
                        jts_pkg::CH_RBRACE:
                        begin
                            tok_v    = 1'b1;
                            tok_kind = jts_pkg::KIND_RBRACE;
                        end
                        jts_pkg::CH_LBRACKET:
                        begin
                            tok_v    = 1'b1;
                            tok_kind = jts_pkg::KIND_LBRACKET;
                        end
                        jts_pkg::CH_RBRACKET:
                        begin
                            tok_v    = 1'b1;
                            tok_kind = jts_pkg::KIND_RBRACKET;
                        end
                        jts_pkg::CH_COMMA:
                        begin
                            tok_v    = 1'b1;
                            tok_kind = jts_pkg::KIND_COMMA;
                        end
                        jts_pkg::CH_COLON:
                        begin
                            tok_v    = 1'b1;
                            tok_kind = jts_pkg::KIND_COLON;
                        end
                        jts_pkg::CH_LOWER_N:
                        begin
                            kw_which_next = jts_pkg::KW_NULL;
                            kw_prog_next  = 3'd1;
                            mode_next     = MODE_KEYWORD;
                            err           = fin;
                        end
                        jts_pkg::CH_LOWER_T:
                        begin
                            kw_which_next = jts_pkg::KW_TRUE;
                            kw_prog_next  = 3'd1;
                            mode_next     = MODE_KEYWORD;
                            err           = fin;
                        end
                        jts_pkg::CH_LOWER_F:
                        begin
                            kw_which_next = jts_pkg::KW_FALSE;
                            kw_prog_next  = 3'd1;
                            mode_next     = MODE_KEYWORD;
                            err           = fin;
                        end
                        jts_pkg::CH_QUOTE:
                        begin
                            mode_next = MODE_STRING;
                            err       = fin;
                        end
                        default:
                        begin
                            if (jts_pkg::is_digit(b))
                            begin
                                mode_next = MODE_NUMBER;
                                err       = fin;
                            end
                            else
                            begin
                                err = 1'b1;
                            end
                        end
                    endcase
                end
            end

            if (err)
            begin
                mode_next        = MODE_IDLE;
                err_latched_next = 1'b1;
            end
        end

        // The final byte of a text always returns the lexer state to its reset values.
        if (fin)
        begin
            mode_next        = MODE_IDLE;
            kw_which_next    = jts_pkg::KW_NULL;
            kw_prog_next     = 3'd0;
            hex_left_next    = 3'd0;
            byte_index_next  = '0;
            err_latched_next = 1'b0;
        end
    end

    // Candidate results in output order: number token, other token, end or error.
    always_comb
    begin
        tail_v          = !err_latched_reg && (err || fin);
        num_res.status  = jts_pkg::ST_TOKEN;
        num_res.kind    = jts_pkg::KIND_NUMBER;
        num_res.pos     = 16'd0;
        tok_res.status  = jts_pkg::ST_TOKEN;
        tok_res.kind    = tok_kind;
        tok_res.pos     = 16'd0;
        tail_res.status = err ? jts_pkg::ST_ERROR : jts_pkg::ST_END;
        tail_res.kind   = 4'd0;
        tail_res.pos    = err ? 16'(byte_index_reg) : 16'd0;

        grp_next[0] = num_res;
        grp_next[1] = tok_res;
        grp_next[2] = tail_res;
        if (!num_v)
        begin
            grp_next[0] = tok_v ? tok_res : tail_res;
            grp_next[1] = tail_res;
        end
        else if (!tok_v)
        begin
            grp_next[1] = tail_res;
        end
        cnt_next = {1'b0, num_v} + {1'b0, tok_v} + {1'b0, tail_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            kw_which_reg    <= jts_pkg::KW_NULL;
            kw_prog_reg     <= 3'd0;
            hex_left_reg    <= 3'd0;
            byte_index_reg  <= '0;
            err_latched_reg <= 1'b0;
            cnt_reg         <= 2'd0;
            rd_reg          <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg        <= mode_next;
                kw_which_reg    <= kw_which_next;
                kw_prog_reg     <= kw_prog_next;
                hex_left_reg    <= hex_left_next;
                byte_index_reg  <= byte_index_next;
                err_latched_reg <= err_latched_next;
                cnt_reg         <= cnt_next;
                rd_reg          <= 2'd0;
            end
            else if (out_fire)
            begin
                if (grp_last)
                begin
                    cnt_reg <= 2'd0;
                    rd_reg  <= 2'd0;
                end
                else
                begin
                    rd_reg <= rd_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            grp_reg[0] <= grp_next[0];
            grp_reg[1] <= grp_next[1];
            grp_reg[2] <= grp_next[2];
        end
    end

endmodule

@@ hdl/jts_checker.sv @@
`timescale 1ns / 1ps
`include "json_token_scanner_core_macros.svh"

module jts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result keeps its contents.
    `JTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // With nothing waiting at the output the scanner takes input.
    `JTS_ASSERT_IMPL(a_ready_when_empty, !m_tvalid, s_tready)

    // End and error results always close the run of a byte.
    `JTS_ASSERT_IMPL(a_tail_is_last, m_tvalid && m_tuser != jts_pkg::ST_TOKEN, m_tlast)

    // Only token, end and error codes appear, and tokens carry no position.
    `JTS_ASSERT_IMPL(a_token_fields,
        m_tvalid && m_tuser == jts_pkg::ST_TOKEN,
        m_tdata[19:4] == 16'd0 && m_tdata[23:20] == 4'd0)

    `JTS_ASSERT_IMPL(a_status_code, m_tvalid,
        m_tuser == jts_pkg::ST_TOKEN || m_tuser == jts_pkg::ST_END ||
        m_tuser == jts_pkg::ST_ERROR)

endmodule

bind json_token_scanner_core jts_checker u_jts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/json_token_scanner_checker.sv @@
`timescale 1ns / 1ps

module json_token_scanner_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // final_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [3:0] token_kind, [19:4] error_position, rest zero
    input  logic [1:0]  m_tuser,   // [1:0] status
    input  logic        m_tlast,   // run_last
    output int          failures,
    output int          pending
);

    import jts_pkg::*;

    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_WORD,
        LEX_NUMBER,
        LEX_STRING,
        LEX_ESCAPE,
        LEX_HEX
    } lex_mode_e;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  kind;
        logic [15:0] pos;
        logic        last;
    } scan_result_t;

    scan_result_t awaited_results[$];
    scan_result_t byte_results[$];

    lex_mode_e   lex_mode = LEX_IDLE;
    logic [1:0]  lex_word = KW_NULL;
    logic [2:0]  lex_word_pos = '0;
    logic [2:0]  lex_hex_left = '0;
    logic [15:0] lex_index = '0;
    logic        lex_dead = 1'b0;
    int          mismatches = 0;

    function automatic logic blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic decimal(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic hex_digit(input logic [7:0] b);
        logic [7:0] folded;
        folded = b | 8'h20;
        return decimal(b) || (folded >= "a" && folded <= "f");
    endfunction

    function automatic string word_spelling(input logic [1:0] w);
        if (w == KW_FALSE)
            return "false";
        else if (w == KW_TRUE)
            return "true";
        return "null";
    endfunction

    function automatic void add_result(input logic [1:0] status, input logic [3:0] kind,
                                       input logic [15:0] pos);
        scan_result_t r;
        r.status = status;
        r.kind = kind;
        r.pos = pos;
        r.last = 1'b0;
        byte_results.insert(byte_results.size(), r);
    endfunction

    function automatic void clear_lexer();
        lex_mode = LEX_IDLE;
        lex_word = KW_NULL;
        lex_word_pos = '0;
        lex_hex_left = '0;
        lex_index = '0;
        lex_dead = 1'b0;
    endfunction

    // A byte seen between tokens. Returns 1 when the byte is an error.
    function automatic logic open_token(input logic [7:0] b, input logic fin);
        logic err;
        err = 1'b0;
        lex_mode = LEX_IDLE;
        if (!blank(b))
        begin
            case (b)
                CH_LBRACE:   add_result(ST_TOKEN, KIND_LBRACE, '0);
                CH_RBRACE:   add_result(ST_TOKEN, KIND_RBRACE, '0);
                CH_LBRACKET: add_result(ST_TOKEN, KIND_LBRACKET, '0);
                CH_RBRACKET: add_result(ST_TOKEN, KIND_RBRACKET, '0);
                CH_COMMA:    add_result(ST_TOKEN, KIND_COMMA, '0);
                CH_COLON:    add_result(ST_TOKEN, KIND_COLON, '0);
                CH_LOWER_N, CH_LOWER_T, CH_LOWER_F:
                begin
                    if (b == CH_LOWER_N)
                        lex_word = KW_NULL;
                    else if (b == CH_LOWER_T)
                        lex_word = KW_TRUE;
                    else
                        lex_word = KW_FALSE;
                    lex_word_pos = 3'd1;
                    lex_mode = LEX_WORD;
                    err = fin;
                end
                CH_QUOTE:
                begin
                    lex_mode = LEX_STRING;
                    err = fin;
                end
                default:
                begin
                    if (decimal(b))
                    begin
                        lex_mode = LEX_NUMBER;
                        err = fin;
                    end
                    else
                        err = 1'b1;
                end
            endcase
        end
        return err;
    endfunction

    // Advances the lexer by one accepted byte and queues the results it causes.
    function automatic void scan_text_byte(input logic [7:0] b, input logic fin);
        logic        err;
        logic [15:0] here_pos;
        string       spelled;
        err = 1'b0;
        here_pos = lex_index;
        byte_results.delete();
        if (lex_dead)
        begin
            // After an error only the final byte matters, and it gives no result.
            if (fin)
                clear_lexer();
            else
                lex_index = lex_index + 16'd1;
            return;
        end
        case (lex_mode)
            LEX_NUMBER:
            begin
                if (decimal(b))
                    err = fin;
                else
                begin
                    add_result(ST_TOKEN, KIND_NUMBER, '0);
                    err = open_token(b, fin);
                end
            end
            LEX_WORD:
            begin
                spelled = word_spelling(lex_word);
                if (lex_word_pos >= spelled.len() || b != spelled[lex_word_pos])
                    err = 1'b1;
                else if (lex_word_pos + 1 == spelled.len())
                begin
                    if (fin)
                        err = 1'b1;
                    else
                    begin
                        add_result(ST_TOKEN,
                                   (lex_word == KW_NULL) ? KIND_NULL : KIND_BOOLEAN, '0);
                        lex_mode = LEX_IDLE;
                    end
                end
                else
                begin
                    lex_word_pos = lex_word_pos + 3'd1;
                    err = fin;
                end
            end
            LEX_STRING:
            begin
                if (b == CH_QUOTE)
                begin
                    if (fin)
                        err = 1'b1;
                    else
                    begin
                        add_result(ST_TOKEN, KIND_STRING, '0);
                        lex_mode = LEX_IDLE;
                    end
                end
                else
                begin
                    if (b == CH_BSLASH)
                        lex_mode = LEX_ESCAPE;
                    err = fin;
                end
            end
            LEX_ESCAPE:
            begin
                case (b)
                    CH_SLASH, CH_QUOTE, CH_BSLASH, CH_LOWER_B, CH_LOWER_F,
                    CH_LOWER_N, CH_LOWER_R, CH_LOWER_T:
                    begin
                        lex_mode = LEX_STRING;
                        err = fin;
                    end
                    CH_LOWER_U:
                    begin
                        lex_mode = LEX_HEX;
                        lex_hex_left = 3'd4;
                        err = fin;
                    end
                    default: err = 1'b1;
                endcase
            end
            LEX_HEX:
            begin
                if (!hex_digit(b))
                    err = 1'b1;
                else
                begin
                    lex_hex_left = lex_hex_left - 3'd1;
                    if (lex_hex_left == 3'd0)
                        lex_mode = LEX_STRING;
                    err = fin;
                end
            end
            default: err = open_token(b, fin);
        endcase

        // End and error results carry a zero kind.
        if (err)
        begin
            add_result(ST_ERROR, '0, here_pos);
            lex_mode = LEX_IDLE;
            lex_dead = 1'b1;
        end
        else if (fin)
            add_result(ST_END, '0, '0);

        if (fin)
            clear_lexer();
        else
            lex_index = lex_index + 16'd1;

        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
        foreach (byte_results[i])
            awaited_results.insert(awaited_results.size(), byte_results[i]);
    endfunction

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : watch_channels
        scan_result_t want;
        if (!rst_n)
        begin
            clear_lexer();
            awaited_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                    note_failure($sformatf(
                        "unexpected result: status %0d kind %0d pos %0d last %0b",
                        m_tuser, m_tdata[3:0], m_tdata[19:4], m_tlast));
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.status || m_tdata[3:0] !== want.kind ||
                        m_tdata[19:4] !== want.pos || m_tdata[23:20] !== 4'h0 ||
                        m_tlast !== want.last)
                        note_failure($sformatf({"result mismatch: expected status %0d ",
                            "kind %0d pos %0d last %0b, got status %0d kind %0d pos %0d ",
                            "last %0b pad %h"}, want.status, want.kind, want.pos,
                            want.last, m_tuser, m_tdata[3:0], m_tdata[19:4], m_tlast,
                            m_tdata[23:20]));
                end
            end
            if (s_tvalid && s_tready)
                scan_text_byte(s_tdata, s_tlast);
        end
        failures <= mismatches;
        pending <= awaited_results.size();
    end

endmodule

@@ tb/tb_json_token_scanner_core.sv @@
`timescale 1ns / 1ps

module tb_json_token_scanner_core;

    import jts_pkg::*;

    localparam int RANDOM_ITEMS    = 450;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int          checker_failures;
    int          results_pending;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          items_sent = 0;
    logic        hold_off_pending = 1'b0;
    logic [7:0]  text_bytes[$];
    string       keywords[3] = '{"null", "true", "false"};

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    json_token_scanner_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    json_token_scanner_checker token_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .failures (checker_failures),
        .pending  (results_pending)
    );

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("json_token_scanner_core verification failed");
                $finish;
            end
        end
    end

    // Result side: the stall style is picked anew at random, one of them never stalls.
    initial
    begin : result_sink
        int style;
        int phase_left;
        int hold;
        style = 0;
        phase_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                m_tready <= 1'b0;
                for (hold = 0; hold < HOLD_OFF_CYCLES; hold++)
                    @(negedge clk);
            end
            if (phase_left == 0)
            begin
                style = $urandom_range(3, 0);
                phase_left = $urandom_range(80, 20);
            end
            phase_left--;
            case (style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(1, 0));
                2:       m_tready <= ($urandom_range(7, 0) != 0);
                default: m_tready <= (phase_left % 4 != 0);
            endcase
        end
    end

    function automatic logic [7:0] byte_in(input int lo, input int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] any_of(input string choices);
        return choices[$urandom_range(choices.len() - 1, 0)];
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(5, 0);
        return (r == 5) ? CH_SPACE : CH_TAB + r[7:0];
    endfunction

    task automatic put_byte(input logic [7:0] value);
        text_bytes.insert(text_bytes.size(), value);
    endtask

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic offer_byte(input logic [7:0] value, input logic fin);
        int gap;
        s_tdata <= value;
        s_tlast <= fin;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(16, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_bytes.size(); i++)
        begin
            offer_byte(text_bytes[i], i == text_bytes.size() - 1);
            items_sent++;
        end
        text_bytes.delete();
    endtask

    task automatic take_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic add_blanks(input int most);
        repeat ($urandom_range(most, 0)) put_byte(blank_char());
    endtask

    task automatic add_hex_digits(input int count);
        repeat (count) put_byte(any_of("0123456789abcdefABCDEF"));
    endtask

    task automatic add_string();
        logic [7:0] c;
        put_byte(CH_QUOTE);
        repeat ($urandom_range(6, 0))
        begin
            case ($urandom_range(3, 0))
                0:
                begin
                    put_byte(CH_BSLASH);
                    put_byte(any_of("/\"\\bfnrt"));
                end
                1:
                begin
                    put_byte(CH_BSLASH);
                    put_byte(CH_LOWER_U);
                    add_hex_digits(4);
                end
                default:
                begin
                    do
                        c = byte_in(0, 255);
                    while (c == CH_QUOTE || c == CH_BSLASH);
                    put_byte(c);
                end
            endcase
        end
        put_byte(CH_QUOTE);
    endtask

    task automatic add_token();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: put_byte(any_of("{}[],:"));
            4, 5:       take_text(keywords[$urandom_range(2, 0)]);
            6, 7:       repeat ($urandom_range(5, 1)) put_byte(byte_in("0", "9"));
            default:    add_string();
        endcase
    endtask

    // Mostly a clean end; sometimes the text stops at or inside the last token.
    task automatic build_clean_text();
        int ending;
        repeat ($urandom_range(8, 1))
        begin
            add_blanks(2);
            add_token();
        end
        ending = $urandom_range(9, 0);
        if (ending < 4)
            put_byte(blank_char());
        else if (ending < 7)
            put_byte(any_of("{}[],:"));
        else if (ending == 9)
            repeat ($urandom_range(2, 1))
                if (text_bytes.size() > 1)
                    text_bytes.delete(text_bytes.size() - 1);
    endtask

    task automatic build_broken_text();
        string w;
        repeat ($urandom_range(3, 0))
        begin
            add_blanks(1);
            add_token();
        end
        add_blanks(1);
        case ($urandom_range(3, 0))
            0:
            begin
                if ($urandom_range(1, 0))
                    put_byte(byte_in(128, 255));
                else
                    put_byte(any_of("#@xZ-+.~!"));
            end
            1:
            begin
                w = keywords[$urandom_range(2, 0)];
                take_text(w.substr(0, $urandom_range(w.len() - 2, 0)));
                put_byte(any_of("xqZ0 }"));
            end
            2:
            begin
                put_byte(CH_QUOTE);
                put_byte(CH_BSLASH);
                put_byte(any_of("aqU0x'"));
            end
            default:
            begin
                put_byte(CH_QUOTE);
                put_byte(CH_BSLASH);
                put_byte(CH_LOWER_U);
                add_hex_digits($urandom_range(3, 0));
                put_byte(any_of("gGz \""));
            end
        endcase
        repeat ($urandom_range(5, 0)) put_byte(byte_in(0, 255));
    endtask

    initial
    begin : stimulus
        int pick;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every punctuation token separated by every whitespace byte, clean end.
        text_bytes = '{CH_LBRACE, CH_TAB, CH_RBRACE, 8'h0A, CH_LBRACKET, 8'h0B,
                       CH_RBRACKET, 8'h0C, CH_COMMA, CH_CR, CH_COLON, CH_SPACE};
        send_text();
        // Number closed by the final byte: number, brace and end from one byte.
        take_text("7}");
        send_text();
        // Keyword completed by the final byte.
        take_text("true");
        send_text();
        // Unicode escape, then a bad escape letter and an ignored final byte.
        take_text("\"\\u0aF9\\qx");
        send_text();
        put_byte(8'hFF);
        send_text();
        // String holding a zero byte, closed by the final byte.
        text_bytes = '{CH_QUOTE, 8'h00, CH_QUOTE};
        send_text();

        hold_off_pending = 1'b1;
        while (items_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(19, 0);
            if (pick < 14)
                build_clean_text();
            else if (pick < 17)
                build_broken_text();
            else
                repeat ($urandom_range(10, 1)) put_byte(byte_in(0, 255));
            send_text();
        end
        s_tvalid <= 1'b0;

        while (results_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (checker_failures == 0 && results_pending == 0)
            $display("json_token_scanner_core verification clean");
        else
            $display("json_token_scanner_core verification failed");
        $finish;
    end

endmodule
